// ----- src/ccbd_pkg.sv -----
package ccbd_pkg;

    typedef struct packed {
        logic        req_type;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  target;
        logic [2:0]  graphics_reg_index;
        logic [7:0]  forward_value;
        logic [14:0] rom_offset;
        logic [3:0]  status;
    } t_out_item;

    // work RAM access request from the decoder
    typedef struct packed {
        logic       rd;
        logic       we;
        logic [7:0] wdata;
    } t_ram_req;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_GFX  = 3'd1;
    localparam logic [2:0] TGT_CTRL = 3'd2;
    localparam logic [2:0] TGT_ROM  = 3'd3;
    localparam logic [2:0] TGT_NONE = 3'd4;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_MIRROR    = 4'd1;
    localparam logic [3:0] ST_IO        = 4'd2;
    localparam logic [3:0] ST_EXT_ROM   = 4'd3;
    localparam logic [3:0] ST_EXT_RAM   = 4'd4;
    localparam logic [3:0] ST_ROM_WRITE = 4'd5;
    localparam logic [3:0] ST_ROM_RANGE = 4'd6;
    localparam logic [3:0] ST_PTR       = 4'd7;
    localparam logic [3:0] ST_STROBE    = 4'd8;

    localparam logic CFG_BUTTON_STATES    = 1'b0;
    localparam logic CFG_PROGRAM_ROM_SIZE = 1'b1;

    localparam logic [15:0] ADDR_RAM_END    = 16'h07FF;
    localparam logic [15:0] ADDR_MIRROR_END = 16'h1FFF;
    localparam logic [15:0] ADDR_GFX_BASE   = 16'h2000;
    localparam logic [15:0] ADDR_GFX_END    = 16'h3FFF;
    localparam logic [15:0] ADDR_IO_END     = 16'h401F;
    localparam logic [15:0] ADDR_EXT_ROM_END = 16'h5FFF;
    localparam logic [15:0] ADDR_EXT_RAM_END = 16'h7FFF;
    localparam logic [15:0] ADDR_ROM_BASE   = 16'h8000;
    localparam logic [15:0] ADDR_CTRL       = 16'h4016;

    localparam logic [7:0]  PTR_ARMED       = 8'hFF;
    localparam logic [7:0]  PTR_LAST        = 8'd7;
    localparam logic [15:0] ROM_SIZE_RESET  = 16'd16384;

endpackage

// ----- src/console_cpu_bus_decoder_unit.sv -----
// Stages: decode + work RAM read into the stage 1 register, then the output
// register. Throughput: 1 item per cycle unless i_out_ready stalls the output;
// the single-port work RAM takes one access per cycle. Reset (synchronous,
// active low) clears the handshake state, the button pointer and the config
// registers; work RAM contents are not cleared and need no clearing pass.
module console_cpu_bus_decoder_unit #(
    parameter int WORK_RAM_DEPTH = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ccbd_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ccbd_pkg::t_out_item  o_out_item
);
    import ccbd_pkg::*;

    localparam int AW = $clog2(WORK_RAM_DEPTH);

    logic [7:0]  r_button_states;
    logic [15:0] r_rom_size;
    logic [7:0]  r_button_pointer;

    logic        r_s1_valid;
    logic        r_s1_ram_rd;
    t_out_item   r_s1_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    t_out_item   dec_item;
    logic [7:0]  n_pointer;
    t_ram_req    dec_ram;
    logic [AW-1:0] dec_ram_addr;
    logic [7:0]  ram_rdata;
    t_out_item   s1_final;

    logic w_advance;
    logic w_in_acc;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_advance;
    assign w_in_acc   = i_in_valid && o_in_ready;

    ccbd_decode #(
        .WORK_RAM_DEPTH(WORK_RAM_DEPTH)
    ) u_decode (
        .i_item          (i_in_item),
        .i_pointer       (r_button_pointer),
        .i_button_states (r_button_states),
        .i_rom_size      (r_rom_size),
        .o_item          (dec_item),
        .o_pointer       (n_pointer),
        .o_ram           (dec_ram),
        .o_ram_addr      (dec_ram_addr)
    );

    // read data holds while stage 1 stalls, since the RAM is only enabled on accept
    ccbd_ram #(
        .WIDTH(8),
        .DEPTH(WORK_RAM_DEPTH)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_en    (w_in_acc && (dec_ram.rd || dec_ram.we)),
        .i_we    (dec_ram.we),
        .i_addr  (dec_ram_addr),
        .i_wdata (dec_ram.wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        s1_final = r_s1_item;
        if (r_s1_ram_rd) begin
            s1_final.read_data = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_states  <= '0;
            r_rom_size       <= ROM_SIZE_RESET;
            r_button_pointer <= '0;
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BUTTON_STATES:    r_button_states <= i_cfg_wdata[7:0];
                    CFG_PROGRAM_ROM_SIZE: r_rom_size      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_button_pointer <= n_pointer;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item   <= dec_item;
            r_s1_ram_rd <= dec_ram.rd;
        end
        if (w_advance && r_s1_valid) begin
            r_out_item <= s1_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_advance) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("stage 1 item lost or changed while stalled");

    a_strobe_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.bus_address == ADDR_CTRL
            && i_in_item.req_type == REQ_WRITE && i_in_item.write_value[0])
        |=> (r_button_pointer == PTR_ARMED))
        else $error("controller strobe did not arm pointer");

    a_ctrl_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.target == TGT_CTRL) |-> (o_out_item.read_data[7:1] == 7'd0))
        else $error("controller read returned more than one bit");

    a_rom_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.target != TGT_ROM) |-> (o_out_item.rom_offset == 15'd0))
        else $error("rom offset set outside ROM target");

endmodule

// ----- src/ccbd_ram.sv -----
module ccbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ccbd_decode.sv -----
module ccbd_decode #(
    parameter int WORK_RAM_DEPTH = 2048
) (
    input  ccbd_pkg::t_in_item                 i_item,
    input  logic [7:0]                         i_pointer,
    input  logic [7:0]                         i_button_states,
    input  logic [15:0]                        i_rom_size,
    output ccbd_pkg::t_out_item                o_item,
    output logic [7:0]                         o_pointer,
    output ccbd_pkg::t_ram_req                 o_ram,
    output logic [$clog2(WORK_RAM_DEPTH)-1:0]  o_ram_addr
);
    import ccbd_pkg::*;

    localparam int AW = $clog2(WORK_RAM_DEPTH);

    logic [15:0] addr;
    logic        wr;
    logic [11:0] ram_idx;
    logic [14:0] ram_wide;
    logic [15:0] rom_off;

    assign addr = i_item.bus_address;
    assign wr   = (i_item.req_type == REQ_WRITE);
    assign rom_off = addr - ADDR_ROM_BASE;
    assign ram_wide = {4'd0, addr[10:0]};

    // RAM window index modulo the depth; for a depth of 256 or more the quotient is
    // at most seven, so the constant multiples are compared side by side and the
    // largest one that fits is subtracted
    always_comb begin
        ram_idx = {1'b0, addr[10:0]};
        for (int k = 1; k < 8; k++) begin
            if (ram_wide >= 15'(k * WORK_RAM_DEPTH)) begin
                ram_idx = 12'(ram_wide - 15'(k * WORK_RAM_DEPTH));
            end
        end
    end

    assign o_ram_addr = ram_idx[AW-1:0];

    always_comb begin
        o_item    = '0;
        o_item.target = TGT_NONE;
        o_item.status = ST_OK;
        o_pointer = i_pointer;
        o_ram     = '0;
        o_ram.wdata = i_item.write_value;

        if (addr <= ADDR_RAM_END) begin
            o_item.target = TGT_RAM;
            o_ram.we = wr;
            o_ram.rd = !wr;
        end else if (addr <= ADDR_MIRROR_END) begin
            o_item.status = ST_MIRROR;
        end else if (addr <= ADDR_GFX_END) begin
            o_item.target = TGT_GFX;
            o_item.graphics_reg_index = 3'((addr - ADDR_GFX_BASE) & 16'h0007);
            if (wr) begin
                o_item.forward_value = i_item.write_value;
            end
        end else if (addr <= ADDR_IO_END) begin
            if (addr == ADDR_CTRL) begin
                o_item.target = TGT_CTRL;
                if (wr) begin
                    if (i_item.write_value[0]) begin
                        o_pointer = PTR_ARMED;
                    end else begin
                        if (i_pointer != PTR_ARMED) begin
                            o_item.status = ST_STROBE;
                        end
                        o_pointer = '0;
                    end
                end else if (i_pointer > PTR_LAST) begin
                    o_item.status = ST_PTR;
                end else begin
                    o_item.read_data = {7'd0, i_button_states[i_pointer[2:0]]};
                    o_pointer = i_pointer + 8'd1;
                end
            end else begin
                o_item.status = ST_IO;
            end
        end else if (addr <= ADDR_EXT_ROM_END) begin
            o_item.status = ST_EXT_ROM;
        end else if (addr <= ADDR_EXT_RAM_END) begin
            o_item.status = ST_EXT_RAM;
        end else begin
            if (wr) begin
                o_item.status = ST_ROM_WRITE;
            end else if (rom_off >= i_rom_size) begin
                o_item.status = ST_ROM_RANGE;
            end else begin
                o_item.target = TGT_ROM;
                o_item.rom_offset = rom_off[14:0];
            end
        end
    end

endmodule

// ----- sim/tb.sv -----
module tb;
    import ccbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAM_WORDS = 2048;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_BUTTON_STATES;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;

    console_cpu_bus_decoder_unit #(
        .WORK_RAM_DEPTH(RAM_WORDS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #5 i_clk = ~i_clk;

    // bus model state and its copy of the config registers
    logic [7:0]  ram_model [RAM_WORDS];
    logic [7:0]  button_ptr_model = '0;
    logic [7:0]  buttons_cfg = '0;
    logic [15:0] rom_size_cfg = ROM_SIZE_RESET;

    t_in_item    pending_accesses [$];
    t_out_item   expected_results [$];
    int unsigned queued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // generator view of work RAM: which entries hold a written byte
    bit          ram_touched [RAM_WORDS];
    logic [15:0] ram_written_addrs [$];

    function automatic t_out_item decode_access(t_in_item acc);
        t_out_item   r;
        logic [15:0] off;
        r = '0;
        r.target = TGT_NONE;
        r.status = ST_OK;
        if (acc.bus_address <= ADDR_RAM_END) begin
            r.target = TGT_RAM;
            if (acc.req_type == REQ_WRITE) begin
                ram_model[acc.bus_address % RAM_WORDS] = acc.write_value;
            end else begin
                r.read_data = ram_model[acc.bus_address % RAM_WORDS];
            end
        end else if (acc.bus_address <= ADDR_MIRROR_END) begin
            r.status = ST_MIRROR;
        end else if (acc.bus_address <= ADDR_GFX_END) begin
            r.target = TGT_GFX;
            r.graphics_reg_index = acc.bus_address[2:0];
            if (acc.req_type == REQ_WRITE) begin
                r.forward_value = acc.write_value;
            end
        end else if (acc.bus_address <= ADDR_IO_END) begin
            if (acc.bus_address == ADDR_CTRL) begin
                r.target = TGT_CTRL;
                if (acc.req_type == REQ_WRITE) begin
                    if (acc.write_value[0]) begin
                        button_ptr_model = PTR_ARMED;
                    end else begin
                        if (button_ptr_model != PTR_ARMED) begin
                            r.status = ST_STROBE;
                        end
                        button_ptr_model = '0;
                    end
                end else if (button_ptr_model > PTR_LAST) begin
                    r.status = ST_PTR;
                end else begin
                    r.read_data = {7'd0, buttons_cfg[button_ptr_model[2:0]]};
                    button_ptr_model = button_ptr_model + 8'd1;
                end
            end else begin
                r.status = ST_IO;
            end
        end else if (acc.bus_address <= ADDR_EXT_ROM_END) begin
            r.status = ST_EXT_ROM;
        end else if (acc.bus_address <= ADDR_EXT_RAM_END) begin
            r.status = ST_EXT_RAM;
        end else begin
            off = acc.bus_address - ADDR_ROM_BASE;
            if (acc.req_type == REQ_WRITE) begin
                r.status = ST_ROM_WRITE;
            end else if (off >= rom_size_cfg) begin
                r.status = ST_ROM_RANGE;
            end else begin
                r.target = TGT_ROM;
                r.rom_offset = off[14:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < 40) begin
            $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // driver: accept bookkeeping plus launch of the next item
    always @(posedge i_clk) begin : driver
        logic launch;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(decode_access(in_item));
                accepted_total++;
            end
            if (!in_valid || in_ready) begin
                launch = (pending_accesses.size() != 0) &&
                         ($urandom_range(99) >= send_idle_pct);
                in_valid <= launch;
                if (launch) begin
                    in_item <= pending_accesses.pop_front();
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(out_item.status), 0);
            end else begin
                want = expected_results.pop_front();
                if (out_item.read_data != want.read_data)
                    report_mismatch("read_data", out_item.read_data, want.read_data);
                if (out_item.target != want.target)
                    report_mismatch("target", out_item.target, want.target);
                if (out_item.graphics_reg_index != want.graphics_reg_index)
                    report_mismatch("graphics_reg_index", out_item.graphics_reg_index,
                                    want.graphics_reg_index);
                if (out_item.forward_value != want.forward_value)
                    report_mismatch("forward_value", out_item.forward_value,
                                    want.forward_value);
                if (out_item.rom_offset != want.rom_offset)
                    report_mismatch("rom_offset", out_item.rom_offset, want.rom_offset);
                if (out_item.status != want.status)
                    report_mismatch("status", out_item.status, want.status);
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // a read of a never-written RAM byte is turned into a write
    task automatic push_access(logic rw, logic [15:0] addr, logic [7:0] val);
        t_in_item it;
        int       idx;
        if (addr <= ADDR_RAM_END) begin
            idx = addr % RAM_WORDS;
            if (!ram_touched[idx]) begin
                rw = REQ_WRITE;
                ram_touched[idx] = 1'b1;
                ram_written_addrs.push_back(addr);
            end
        end
        it.req_type = rw;
        it.bus_address = addr;
        it.write_value = val;
        pending_accesses.push_back(it);
        queued_total++;
    endtask

    task automatic gen_random_access();
        int unsigned pick;
        int          off;
        logic        rw;
        pick = $urandom_range(99);
        rw = 1'($urandom_range(1));
        if (pick < 25) begin
            if (ram_written_addrs.size() != 0 && rw == REQ_READ) begin
                push_access(REQ_READ,
                            ram_written_addrs[$urandom_range(ram_written_addrs.size() - 1)],
                            8'($urandom));
            end else begin
                push_access(REQ_WRITE, 16'($urandom_range(ADDR_RAM_END)), 8'($urandom));
            end
        end else if (pick < 40) begin
            // strobe then serial reads; sometimes the arm or release is missing
            if ($urandom_range(4) != 0)
                push_access(REQ_WRITE, ADDR_CTRL, {7'($urandom), 1'b1});
            if ($urandom_range(9) != 0)
                push_access(REQ_WRITE, ADDR_CTRL, {7'($urandom), 1'b0});
            repeat ($urandom_range(10)) push_access(REQ_READ, ADDR_CTRL, 8'($urandom));
        end else if (pick < 50) begin
            push_access(rw, 16'($urandom_range(ADDR_GFX_END, ADDR_GFX_BASE)), 8'($urandom));
        end else if (pick < 55) begin
            push_access(rw, 16'($urandom_range(ADDR_MIRROR_END, ADDR_RAM_END + 1)),
                        8'($urandom));
        end else if (pick < 60) begin
            push_access(rw, 16'($urandom_range(ADDR_IO_END, ADDR_GFX_END + 1)), 8'($urandom));
        end else if (pick < 65) begin
            push_access(rw, 16'($urandom_range(ADDR_EXT_ROM_END, ADDR_IO_END + 1)),
                        8'($urandom));
        end else if (pick < 70) begin
            push_access(rw, 16'($urandom_range(ADDR_EXT_RAM_END, ADDR_EXT_ROM_END + 1)),
                        8'($urandom));
        end else if (pick < 95) begin
            rw = ($urandom_range(3) == 0) ? REQ_WRITE : REQ_READ;
            if ($urandom_range(9) < 4) begin
                // around the end of the ROM image
                off = int'(rom_size_cfg) + int'($urandom_range(4)) - 2;
                if (off < 0) off = 0;
                if (off > 32767) off = 32767;
            end else begin
                off = $urandom_range(32767);
            end
            push_access(rw, ADDR_ROM_BASE + 16'(off), 8'($urandom));
        end else begin
            push_access(rw, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_BUTTON_STATES) buttons_cfg = val[7:0];
        else rom_size_cfg = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned start;
        logic [7:0]  btn_sel;
        logic [15:0] rom_sel;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_stall_pct = 78;
        push_access(REQ_WRITE, 16'h0000, 8'hFF);
        push_access(REQ_WRITE, ADDR_RAM_END, 8'h00);
        push_access(REQ_READ, 16'h0000, 8'h00);
        push_access(REQ_READ, ADDR_RAM_END, 8'hFF);
        push_access(REQ_READ, ADDR_RAM_END + 1, 8'h00);
        push_access(REQ_WRITE, ADDR_MIRROR_END, 8'hFF);
        push_access(REQ_WRITE, ADDR_GFX_BASE, 8'h5A);
        push_access(REQ_READ, ADDR_GFX_END, 8'hA5);
        push_access(REQ_WRITE, ADDR_GFX_END + 1, 8'h12);
        push_access(REQ_READ, ADDR_IO_END, 8'h00);
        push_access(REQ_WRITE, ADDR_CTRL, 8'h00);   // release without arm
        push_access(REQ_READ, ADDR_CTRL, 8'h00);
        push_access(REQ_WRITE, ADDR_CTRL, 8'h01);   // arm
        push_access(REQ_READ, ADDR_CTRL, 8'h00);    // armed pointer read
        push_access(REQ_WRITE, ADDR_CTRL, 8'hFE);   // release after arm
        push_access(REQ_READ, ADDR_IO_END + 1, 8'h00);
        push_access(REQ_WRITE, ADDR_EXT_ROM_END, 8'hFF);
        push_access(REQ_READ, ADDR_EXT_ROM_END + 1, 8'h00);
        push_access(REQ_WRITE, ADDR_EXT_RAM_END, 8'h77);
        push_access(REQ_READ, ADDR_ROM_BASE, 8'h00);
        push_access(REQ_READ, ADDR_ROM_BASE + ROM_SIZE_RESET - 16'd1, 8'h00);
        push_access(REQ_READ, ADDR_ROM_BASE + ROM_SIZE_RESET, 8'h00);
        push_access(REQ_READ, 16'hFFFF, 8'h00);
        push_access(REQ_WRITE, ADDR_ROM_BASE, 8'hC3);

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p / 2)
                0: begin
                    send_idle_pct = 23;
                    recv_stall_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_stall_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (p)
                0: begin btn_sel = 8'h00; rom_sel = 16'd0;     end
                1: begin btn_sel = 8'hFF; rom_sel = 16'd32768; end
                2: begin btn_sel = 8'($urandom); rom_sel = 16'd1; end
                3: begin btn_sel = 8'($urandom); rom_sel = ROM_SIZE_RESET; end
                default: begin
                    btn_sel = 8'($urandom);
                    rom_sel = 16'($urandom_range(32768));
                end
            endcase
            write_cfg(CFG_BUTTON_STATES, {8'd0, btn_sel});
            write_cfg(CFG_PROGRAM_ROM_SIZE, rom_sel);
            start = queued_total;
            while (queued_total - start < 290) gen_random_access();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ccbd_pkg.sv
src/ccbd_ram.sv
src/ccbd_decode.sv
src/console_cpu_bus_decoder_unit.sv
sim/tb.sv
